// ===== hw/rtl/grid_heat_diffusion_stepper_top_defines.svh =====
// assertion macros for the grid heat diffusion stepper
// no dependencies
`ifndef GRID_HEAT_DIFFUSION_STEPPER_TOP_DEFINES_SVH
`define GRID_HEAT_DIFFUSION_STEPPER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GHD_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define GHD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define GHD_ASSERT_IMPL(label, clk, rst_n, prop)
`define GHD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== hw/rtl/ghd_pkg.sv =====
// shared types and constants for the grid heat diffusion stepper
// no dependencies
package ghd_pkg;
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] REG_TIME_STEP    = 3'd0;
    localparam logic [2:0] REG_END_TIME     = 3'd1;
    localparam logic [2:0] REG_CONDUCTANCE  = 3'd2;
    localparam logic [2:0] REG_CELL_VOLUME  = 3'd3;
    localparam logic [2:0] REG_CONTRIBUTION = 3'd4;
    localparam logic [2:0] REG_GRID_ROWS    = 3'd5;
    localparam logic [2:0] REG_GRID_COLS    = 3'd6;

    // datapath operations
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_RD_C   = 4'd1;  // read center temp and density
    localparam logic [3:0] OP_RD_N   = 4'd2;  // read one neighbor, accumulate
    localparam logic [3:0] OP_MUL_NA = 4'd3;  // numerator low product
    localparam logic [3:0] OP_MUL_DA = 4'd4;  // denominator partial
    localparam logic [3:0] OP_DIV    = 4'd5;  // one divider bit
    localparam logic [3:0] OP_WR_CH  = 4'd6;  // store change
    localparam logic [3:0] OP_RD_AP  = 4'd7;  // read temp and change for apply
    localparam logic [3:0] OP_WR_AP  = 4'd8;  // write new temp
    localparam logic [3:0] OP_PREP   = 4'd9;  // global products dt*h
    localparam logic [3:0] OP_MUL_NB = 4'd10;
    localparam logic [3:0] OP_MUL_DB = 4'd11;
    localparam logic [3:0] OP_MUL_DC = 4'd12;
    localparam logic [3:0] OP_MUL_DD = 4'd13;
    localparam logic [3:0] OP_PREP2  = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] nsel;   // neighbor 0..3
        logic [7:0] bitn;   // divider bit index
    } t_cmd;

    typedef struct packed {
        logic den_zero;
    } t_stat;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] temperature;
        logic [31:0] density;
    } t_in_item;

    typedef struct packed {
        logic [31:0] cell_temperature;
        logic [31:0] steps_run;
        logic        status;
    } t_out_item;

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) return 32'h7fffffff;
        else if (v < -35'sd2147483648) return 32'h80000000;
        else return v[31:0];
    endfunction
endpackage

// ===== hw/rtl/ghd_stream_if.sv =====
// valid/ready channel carrying a payload of parameterized type
// depends on nothing
interface ghd_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ghd_ram.sv =====
// generic single-port write, single read ram with registered read
// no dependencies
module ghd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/ghd_datapath.sv =====
// stores, stencil accumulation, multiplies and restoring divider
// depends on ghd_pkg and ghd_ram
module ghd_datapath import ghd_pkg::*; #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_addr,
    input  logic          i_ext_we,
    input  logic [AW-1:0] i_ext_addr,
    input  logic [31:0]   i_ext_temp,
    input  logic [31:0]   i_ext_dens,
    input  logic [31:0]   i_time_step,
    input  logic [31:0]   i_conductance,
    input  logic [31:0]   i_cell_volume,
    input  logic [31:0]   i_contribution,
    output logic [31:0]   o_temp_rd,
    output t_stat         o_stat
);
    logic [31:0] w_trd, w_drd, w_crd;
    logic        w_twe, w_cwe;
    logic [AW-1:0] w_twa;
    logic [31:0] w_twd;
    logic [31:0] r_tc, r_dens;
    logic signed [35:0] r_lap;
    logic [63:0] r_dth, r_dv;
    logic [34:0] r_mag;
    logic [127:0] r_num, r_den, r_rem, r_q;
    logic [31:0] r_chg;
    logic        r_neg;
    logic [3:0]  r_op_d;
    logic signed [35:0] w_lapn;
    logic [128:0] w_sh;
    logic [63:0] w_pl;

    assign w_twe = i_ext_we || (i_cmd.op == OP_WR_AP);
    assign w_twa = i_ext_we ? i_ext_addr : i_addr;
    assign w_cwe = (i_cmd.op == OP_WR_CH);

    ghd_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_temp (
        .i_clk, .i_we(w_twe), .i_waddr(w_twa), .i_wdata(w_twd),
        .i_raddr(i_addr), .o_rdata(w_trd));
    ghd_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_dens (
        .i_clk, .i_we(i_ext_we), .i_waddr(i_ext_addr), .i_wdata(i_ext_dens),
        .i_raddr(i_addr), .o_rdata(w_drd));
    ghd_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_chg (
        .i_clk, .i_we(w_cwe), .i_waddr(i_addr), .i_wdata(r_chg),
        .i_raddr(i_addr), .o_rdata(w_crd));

    assign w_twd = i_ext_we ? i_ext_temp
        : sat32(35'($signed(r_tc)) + 35'($signed(w_crd)));
    assign o_temp_rd = w_trd;
    assign o_stat.den_zero = (r_den == '0);
    assign w_lapn = r_lap + 36'($signed(w_trd));
    assign w_sh = {r_rem, r_num[127]};
    assign w_pl = 64'(r_mag[31:0]) * 64'(r_dth[31:0]);

    always_ff @(posedge i_clk) begin
        r_op_d <= i_cmd.op;
        case (r_op_d)
            OP_RD_C: begin
                r_tc   <= w_trd;
                r_dens <= w_drd;
                r_lap  <= -36'($signed(w_trd)) * 36'sd4;
            end
            OP_RD_N: r_lap <= w_lapn;
            OP_RD_AP: r_tc <= w_trd;
            default: ;
        endcase
        case (i_cmd.op)
            OP_PREP: r_dth <= 64'(i_time_step) * 64'(i_conductance);
            OP_PREP2: begin
                r_neg <= r_lap[35];
                r_mag <= r_lap[35] ? 35'(-r_lap) : 35'(r_lap);
                r_num <= '0;
            end
            OP_MUL_NA: r_num <= r_num + 128'(w_pl);
            OP_MUL_NB: r_num <= r_num
                + (128'(64'(r_mag[31:0]) * 64'(r_dth[63:32])) << 32)
                + (128'(64'(r_mag[34:32]) * 64'(r_dth[31:0])) << 32)
                + (128'(64'(r_mag[34:32]) * 64'(r_dth[63:32])) << 64);
            OP_MUL_DA: begin
                r_dv  <= 64'(r_dens) * 64'(i_cell_volume);
                r_den <= '0;
            end
            OP_MUL_DB: r_den <= 128'(64'(r_dv[31:0]) * 64'(i_contribution));
            OP_MUL_DC: r_den <= r_den
                + (128'(64'(r_dv[63:32]) * 64'(i_contribution)) << 32);
            OP_MUL_DD: begin
                r_rem <= '0;
                r_q   <= '0;
            end
            OP_DIV: begin
                r_num <= {r_num[126:0], 1'b0};
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= 128'(w_sh - {1'b0, r_den});
                    r_q   <= {r_q[126:0], 1'b1};
                end else begin
                    r_rem <= w_sh[127:0];
                    r_q   <= {r_q[126:0], 1'b0};
                end
            end
            OP_WR_CH: ;
            default: ;
        endcase
        if (i_cmd.op == OP_MUL_DD || i_cmd.op == OP_DIV) begin
            // result formed after last divide step
        end
        if (r_op_d == OP_DIV && i_cmd.op != OP_DIV) begin
            if (r_den == '0) r_chg <= '0;
            else if (r_neg)
                r_chg <= (r_q > 128'h80000000) ? 32'h80000000 : 32'(-r_q[31:0]);
            else
                r_chg <= (r_q > 128'h7fffffff) ? 32'h7fffffff : r_q[31:0];
        end
    end
endmodule

// ===== hw/rtl/ghd_ctrl.sv =====
// sequencer for commands and diffusion steps
// depends on ghd_pkg
module ghd_ctrl import ghd_pkg::*; #(
    parameter int RW = 6,
    parameter int CW = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [RW:0]     i_rows,
    input  logic [CW:0]     i_cols,
    input  logic [31:0]     i_time_step,
    input  logic [31:0]     i_end_time,
    input  t_stat           i_stat,
    output t_cmd            o_cmd,
    output logic [RW+CW-1:0] o_addr,
    output logic            o_busy,
    output logic            o_done,
    output logic [31:0]     o_steps
);
    localparam logic [3:0] S_IDLE = 4'd0, S_PREP = 4'd1, S_RDC = 4'd2, S_RDN = 4'd3,
        S_WAIT = 4'd4, S_MUL = 4'd5, S_DIV = 4'd6, S_WRC = 4'd7, S_RDA = 4'd8,
        S_WRA = 4'd9, S_NEXT = 4'd10, S_DONE = 4'd11;
    logic [3:0] r_st, n_st;
    logic [RW-1:0] r_r, n_r;
    logic [CW-1:0] r_c, n_c;
    logic [3:0] r_k, n_k;
    logic [7:0] r_b, n_b;
    logic r_apply, n_apply;
    logic [32:0] r_el, n_el;
    logic [31:0] r_steps, n_steps;
    logic last_c, last_r;
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;

    assign last_c = (CW+1)'(r_c) + 1'b1 >= i_cols;
    assign last_r = (RW+1)'(r_r) + 1'b1 >= i_rows;

    always_comb begin
        nr = r_r;
        nc = r_c;
        case (r_k[1:0])
            2'd0: if (r_r != '0) nr = r_r - 1'b1;
            2'd1: if (!last_r) nr = r_r + 1'b1;
            2'd2: if (r_c != '0) nc = r_c - 1'b1;
            default: if (!last_c) nc = r_c + 1'b1;
        endcase
    end

    always_comb begin
        n_st = r_st; n_r = r_r; n_c = r_c; n_k = r_k; n_b = r_b;
        n_apply = r_apply; n_el = r_el; n_steps = r_steps;
        o_cmd = '0;
        o_addr = {r_r, r_c};
        o_done = 1'b0;
        case (r_st)
            S_IDLE: if (i_start) begin
                n_st = S_PREP; n_el = '0; n_steps = '0;
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                n_r = '0; n_c = '0; n_apply = 1'b0; n_st = S_RDC;
            end
            S_RDC: begin
                o_cmd.op = OP_RD_C; n_k = '0; n_st = S_RDN;
            end
            S_RDN: begin
                o_cmd.op = OP_RD_N; o_addr = {nr, nc};
                n_k = r_k + 1'b1;
                if (r_k == 4'd3) begin n_st = S_WAIT; n_k = '0; end
            end
            S_WAIT: begin
                n_k = r_k + 1'b1;
                if (r_k == 4'd1) begin n_st = S_MUL; n_k = '0; end
            end
            S_MUL: begin
                case (r_k)
                    4'd0: o_cmd.op = OP_PREP2;
                    4'd1: o_cmd.op = OP_MUL_NA;
                    4'd2: o_cmd.op = OP_MUL_NB;
                    4'd3: o_cmd.op = OP_MUL_DA;
                    4'd4: o_cmd.op = OP_MUL_DB;
                    4'd5: o_cmd.op = OP_MUL_DC;
                    default: o_cmd.op = OP_MUL_DD;
                endcase
                n_k = r_k + 1'b1;
                if (r_k == 4'd6) begin n_st = S_DIV; n_b = '0; n_k = '0; end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV; o_cmd.bitn = r_b;
                n_b = r_b + 1'b1;
                // zero divisor gives a zero change, no need to run all bits
                if (r_b == 8'd127 || i_stat.den_zero) n_st = S_WRC;
            end
            S_WRC: begin
                n_k = r_k + 1'b1;
                if (r_k == 4'd7) begin
                    o_cmd.op = OP_WR_CH; n_st = S_NEXT; n_k = '0;
                end
            end
            S_RDA: begin
                o_cmd.op = OP_RD_AP; n_st = S_WAIT; n_k = 4'd8;
            end
            S_WRA: begin
                o_cmd.op = OP_WR_AP; n_st = S_NEXT;
            end
            S_NEXT: begin
                n_st = r_apply ? S_RDA : S_RDC;
                if (last_c) begin
                    n_c = '0;
                    if (last_r) begin
                        n_r = '0;
                        if (!r_apply) begin
                            n_apply = 1'b1;
                            n_st = S_RDA;
                        end else begin
                            n_steps = r_steps + 1'b1;
                            n_el = r_el + 33'(i_time_step);
                            n_st = (i_time_step != '0 && n_el < 33'(i_end_time))
                                ? S_PREP : S_DONE;
                        end
                    end else n_r = r_r + 1'b1;
                end else n_c = r_c + 1'b1;
            end
            S_DONE: begin
                o_done = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
        // apply read waits on change ram latency then writes
        if (r_st == S_WAIT && r_k >= 4'd8) begin
            n_k = r_k + 1'b1;
            n_st = (r_k == 4'd9) ? S_WRA : S_WAIT;
        end
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_steps = r_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_r <= '0; r_c <= '0; r_k <= '0; r_b <= '0;
            r_apply <= 1'b0; r_el <= '0; r_steps <= '0;
        end else begin
            r_st <= n_st; r_r <= n_r; r_c <= n_c; r_k <= n_k; r_b <= n_b;
            r_apply <= n_apply; r_el <= n_el; r_steps <= n_steps;
        end
    end
endmodule

// ===== hw/rtl/grid_heat_diffusion_stepper_top.sv =====
// channel | role   | fields
// in_if   | sink   | command, row, col, temperature, density
// out_if  | source | cell_temperature, steps_run, status
// cfg     | write  | i_cfg_we, i_cfg_index, i_cfg_data
// write, read and unknown commands fill the output register from the result phase
// the next item is taken no sooner than the cycle after the result leaves
// each run step walks all cells: stencil reads, multiplies, the one-bit-a-cycle
// divider (cut short on a zero divisor) and the change write, then an apply walk
// reset is synchronous active low; the stores hold no reset value
// a result waits in the output register and holds off the input until taken
`include "grid_heat_diffusion_stepper_top_defines.svh"
module grid_heat_diffusion_stepper_top import ghd_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ghd_stream_if.sink   in_if,
    ghd_stream_if.source out_if,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam logic [1:0] P_IDLE = 2'd0, P_RESULT = 2'd1, P_RUN = 2'd2;

    logic [31:0] r_ts, r_et, r_h, r_vol, r_con;
    logic [6:0]  r_gr, r_gc;
    logic [RW:0] w_rows;
    logic [CW:0] w_cols;
    logic [1:0]  r_ph;
    logic [1:0]  r_cmd;
    logic        r_ins;
    logic        r_ov;
    logic [31:0] r_ot, r_os;
    logic        r_ost;
    t_cmd        w_cmd;
    logic [AW-1:0] w_caddr, w_addr;
    logic        w_busy, w_done, w_start, w_acc, w_ins;
    logic [31:0] w_steps, w_trd;
    t_stat       w_stat;

    assign w_rows = (r_gr == '0) ? (RW+1)'(1)
        : (32'(r_gr) > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(r_gr);
    assign w_cols = (r_gc == '0) ? (CW+1)'(1)
        : (32'(r_gc) > MAX_COLS) ? (CW+1)'(MAX_COLS) : (CW+1)'(r_gc);

    assign in_if.ready = (r_ph == P_IDLE) && !r_ov;
    assign w_acc = in_if.valid && in_if.ready;
    assign w_ins = (32'(in_if.data.row) < 32'(w_rows)) && (32'(in_if.data.col) < 32'(w_cols));
    assign w_start = w_acc && in_if.data.command == CMD_RUN;
    assign w_addr = w_busy ? w_caddr
        : {RW'(in_if.data.row), CW'(in_if.data.col)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= 32'd65536; r_et <= '0; r_h <= 32'd65536; r_vol <= 32'd65536;
            r_con <= 32'd100000000; r_gr <= 7'd64; r_gc <= 7'd64;
            r_ph <= P_IDLE; r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TIME_STEP:    r_ts <= i_cfg_data;
                    REG_END_TIME:     r_et <= i_cfg_data;
                    REG_CONDUCTANCE:  r_h <= i_cfg_data;
                    REG_CELL_VOLUME:  r_vol <= i_cfg_data;
                    REG_CONTRIBUTION: r_con <= i_cfg_data;
                    REG_GRID_ROWS:    r_gr <= i_cfg_data[6:0];
                    REG_GRID_COLS:    r_gc <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) r_ov <= 1'b0;
            case (r_ph)
                P_IDLE: if (w_acc) begin
                    r_cmd <= in_if.data.command;
                    r_ins <= w_ins;
                    r_ph  <= (in_if.data.command == CMD_RUN) ? P_RUN : P_RESULT;
                end
                P_RESULT: begin
                    r_ov  <= 1'b1;
                    r_ot  <= (r_cmd == CMD_READ && r_ins) ? w_trd : '0;
                    r_os  <= '0;
                    r_ost <= (r_cmd == CMD_WRITE || r_cmd == CMD_READ) && !r_ins;
                    r_ph  <= P_IDLE;
                end
                P_RUN: if (w_done) begin
                    r_ov <= 1'b1; r_ot <= '0; r_os <= w_steps; r_ost <= 1'b0;
                    r_ph <= P_IDLE;
                end
                default: r_ph <= P_IDLE;
            endcase
        end
    end

    assign out_if.valid = r_ov;
    assign out_if.data.cell_temperature = r_ot;
    assign out_if.data.steps_run = r_os;
    assign out_if.data.status = r_ost;

    ghd_ctrl #(.RW(RW), .CW(CW)) u_ctrl (
        .i_clk, .i_rst_n, .i_start(w_start), .i_rows(w_rows), .i_cols(w_cols),
        .i_time_step(r_ts), .i_end_time(r_et), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_addr(w_caddr), .o_busy(w_busy), .o_done(w_done), .o_steps(w_steps));

    ghd_datapath #(.AW(AW)) u_dp (
        .i_clk, .i_cmd(w_cmd), .i_addr(w_addr),
        .i_ext_we(w_acc && in_if.data.command == CMD_WRITE && w_ins),
        .i_ext_addr({RW'(in_if.data.row), CW'(in_if.data.col)}),
        .i_ext_temp(in_if.data.temperature), .i_ext_dens(in_if.data.density),
        .i_time_step(r_ts), .i_conductance(r_h), .i_cell_volume(r_vol),
        .i_contribution(r_con), .o_temp_rd(w_trd), .o_stat(w_stat));

    `GHD_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, w_start, w_busy)
    `GHD_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, w_busy |-> !in_if.ready)
    `GHD_ASSERT_IMPL(a_done_run, i_clk, i_rst_n, w_done |-> r_ph == P_RUN)
endmodule

// ===== verif/tb.sv =====
// self-checking bench for grid_heat_diffusion_stepper_top: loads, runs and reads small grids
// predicts each result in-bench and compares results in order; needs ghd_pkg and ghd_stream_if
`timescale 1ns / 100ps
module tb import ghd_pkg::*; ();

    localparam int NROWS = 64;
    localparam int NCOLS = 64;
    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    ghd_stream_if #(.T(t_in_item)) in_if ();
    ghd_stream_if #(.T(t_out_item)) out_if ();

    grid_heat_diffusion_stepper_top #(.MAX_ROWS(NROWS), .MAX_COLS(NCOLS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .in_if(in_if),
        .out_if(out_if),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow configuration
    logic [31:0] dt_q = 32'd65536;
    logic [31:0] end_q = 32'd0;
    logic [31:0] cond_q = 32'd65536;
    logic [31:0] vol_q = 32'd65536;
    logic [31:0] contrib_q = 32'd100000000;
    logic [6:0]  rows_q = 7'd64;
    logic [6:0]  cols_q = 7'd64;

    logic [31:0] temp_mem [NROWS*NCOLS];
    logic [31:0] dens_mem [NROWS*NCOLS];
    logic [31:0] delta_mem [NROWS*NCOLS];
    bit          loaded [NROWS*NCOLS];

    t_in_item pending_cmds[$];
    t_out_item expected_results[$];
    int  mismatches = 0;
    bit  quiet = 1'b0;
    bit  hold_tx = 1'b0;
    bit  stall_req = 1'b0;
    bit  stall_done = 1'b0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  rx_hold = 0;
    int  cycles = 0;

    function automatic int rows_used();
        return (rows_q < 1) ? 1 : (rows_q > NROWS) ? NROWS : int'(rows_q);
    endfunction

    function automatic int cols_used();
        return (cols_q < 1) ? 1 : (cols_q > NCOLS) ? NCOLS : int'(cols_q);
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [36:0] v);
        if (v > 37'sd2147483647) return 32'h7fffffff;
        if (v < -37'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] heat_change(input logic signed [36:0] lap,
                                                input logic [31:0] dens);
        logic [36:0]  mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        mag = (lap < 0) ? -lap : lap;
        num = 128'(dt_q) * 128'(cond_q) * 128'(mag);
        den = 128'(dens) * 128'(vol_q) * 128'(contrib_q);
        if (den == 0) return 32'd0;
        q = num / den;
        if (lap < 0) begin
            if (q > 128'h80000000) q = 128'h80000000;
            return -q[31:0];
        end
        if (q > 128'h7fffffff) q = 128'h7fffffff;
        return q[31:0];
    endfunction

    task automatic diffuse_once();
        int rows;
        int cols;
        int idx;
        logic signed [36:0] lap;
        rows = rows_used();
        cols = cols_used();
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                idx = r * NCOLS + c;
                lap = 37'($signed(temp_mem[(r > 0) ? idx - NCOLS : idx]))
                    + 37'($signed(temp_mem[(r + 1 < rows) ? idx + NCOLS : idx]))
                    + 37'($signed(temp_mem[(c > 0) ? idx - 1 : idx]))
                    + 37'($signed(temp_mem[(c + 1 < cols) ? idx + 1 : idx]))
                    - 37'sd4 * 37'($signed(temp_mem[idx]));
                delta_mem[idx] = heat_change(lap, dens_mem[idx]);
            end
        end
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                idx = r * NCOLS + c;
                temp_mem[idx] = clamp32(37'($signed(temp_mem[idx]))
                                      + 37'($signed(delta_mem[idx])));
            end
        end
    endtask

    task automatic predict_response(input t_in_item it);
        t_out_item res;
        bit in_grid;
        int idx;
        logic [32:0] elapsed;
        logic [31:0] steps;
        res = '0;
        in_grid = (it.row < rows_used()) && (it.col < cols_used());
        idx = it.row * NCOLS + it.col;
        case (it.command)
            CMD_WRITE: begin
                if (in_grid) begin
                    temp_mem[idx] = it.temperature;
                    dens_mem[idx] = it.density;
                end else begin
                    res.status = 1'b1;
                end
            end
            CMD_RUN: begin
                elapsed = '0;
                steps = '0;
                do begin
                    diffuse_once();
                    steps++;
                    elapsed = elapsed + 33'(dt_q);
                end while (dt_q != 0 && elapsed < 33'(end_q));
                res.steps_run = steps;
            end
            CMD_READ: begin
                if (in_grid) res.cell_temperature = temp_mem[idx];
                else res.status = 1'b1;
            end
            default: ;
        endcase
        expected_results.push_back(res);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result temp=%h steps=%0d status=%0d",
                         got.cell_temperature, got.steps_run, got.status);
            return;
        end
        want = expected_results.pop_front();
        if (got.cell_temperature !== want.cell_temperature || got.steps_run !== want.steps_run
                || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp t=%h s=%0d st=%0d got t=%h s=%0d st=%0d",
                         want.cell_temperature, want.steps_run, want.status,
                         got.cell_temperature, got.steps_run, got.status);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data <= '0;
        end else begin
            if (in_if.valid && in_if.ready) predict_response(in_if.data);
            if (!in_if.valid || in_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_cmds.size() > 0 && !hold_tx) begin
                    if (!quiet && $urandom_range(0, 5) == 0) begin
                        tx_gap = $urandom_range(0, 3);
                        in_if.valid <= 1'b0;
                    end else begin
                        in_if.data <= pending_cmds.pop_front();
                        in_if.valid <= 1'b1;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold <= 0;
        end else if (stall_req && !stall_done) begin
            rx_hold <= 400;
            stall_done <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) check_result(out_if.data);
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 3);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_cmds.size() > 0 || in_if.valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        case (index)
            REG_TIME_STEP:    dt_q = value;
            REG_END_TIME:     end_q = value;
            REG_CONDUCTANCE:  cond_q = value;
            REG_CELL_VOLUME:  vol_q = value;
            REG_CONTRIBUTION: contrib_q = value;
            REG_GRID_ROWS:    rows_q = value[6:0];
            REG_GRID_COLS:    cols_q = value[6:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_cmd(input logic [1:0] cmd, input logic [5:0] row,
                            input logic [5:0] col, input logic [31:0] temp,
                            input logic [31:0] dens);
        t_in_item it;
        it.command = cmd;
        it.row = row;
        it.col = col;
        it.temperature = temp;
        it.density = dens;
        if (cmd == CMD_WRITE && row < rows_used() && col < cols_used())
            loaded[row * NCOLS + col] = 1'b1;
        pending_cmds.push_back(it);
    endtask

    function automatic logic [31:0] rand_density();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 16);
            1: return $urandom_range(1, 32'h20000);
            2: return 32'hffffffff;
            default: return ($urandom() == 0) ? 32'd1 : $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_temp();
        case ($urandom_range(0, 3))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            default: return $urandom();
        endcase
    endfunction

    task automatic apply_setting(input logic [31:0] dt, input logic [31:0] tend,
                                 input logic [31:0] h, input logic [31:0] vol,
                                 input logic [31:0] c, input logic [6:0] rows,
                                 input logic [6:0] cols);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_END_TIME, tend);
        write_reg(REG_CONDUCTANCE, h);
        write_reg(REG_CELL_VOLUME, vol);
        write_reg(REG_CONTRIBUTION, c);
        write_reg(REG_GRID_ROWS, 32'(rows));
        write_reg(REG_GRID_COLS, 32'(cols));
        // every cell in use gets loaded before anything can read it
        for (int r = 0; r < rows_used(); r++)
            for (int k = 0; k < cols_used(); k++)
                if (!loaded[r * NCOLS + k])
                    push_cmd(CMD_WRITE, 6'(r), 6'(k), rand_temp(), rand_density());
    endtask

    task automatic random_items(input int count);
        int sel;
        logic [5:0] row;
        logic [5:0] col;
        logic [1:0] cmd;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            cmd = (sel < 45) ? CMD_WRITE : (sel < 91) ? CMD_READ :
                  (sel < 95) ? CMD_RUN : CMD_UNKNOWN;
            if ($urandom_range(0, 4) == 0) begin
                row = 6'($urandom());
                col = 6'($urandom());
            end else begin
                row = 6'($urandom_range(0, rows_used() - 1));
                col = 6'($urandom_range(0, cols_used() - 1));
            end
            // keep reads off cells that were never loaded
            if (cmd == CMD_READ && row < rows_used() && col < cols_used()
                    && !loaded[row * NCOLS + col]) cmd = CMD_WRITE;
            push_cmd(cmd, row, col, rand_temp(), rand_density());
        end
    endtask

    initial begin
        logic [31:0] dt;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small grid, field extremes, edges, bad index, unknown command
        apply_setting(32'd65536, 32'd0, 32'd65536, 32'd65536, 32'd100000000, 7'd2, 7'd3);
        pending_cmds.delete();
        push_cmd(CMD_WRITE, 6'd0, 6'd0, 32'h7fffffff, 32'd1);
        push_cmd(CMD_WRITE, 6'd0, 6'd1, 32'h80000000, 32'hffffffff);
        push_cmd(CMD_WRITE, 6'd0, 6'd2, 32'd0, 32'd1);
        push_cmd(CMD_WRITE, 6'd1, 6'd0, 32'hffffffff, 32'd65536);
        push_cmd(CMD_WRITE, 6'd1, 6'd1, 32'h00010000, 32'd2);
        push_cmd(CMD_WRITE, 6'd1, 6'd2, 32'h55555555, 32'haaaaaaaa);
        push_cmd(CMD_WRITE, 6'd63, 6'd63, 32'h12345678, 32'd1);
        push_cmd(CMD_READ, 6'd63, 6'd0, 32'd0, 32'd1);
        push_cmd(CMD_READ, 6'd0, 6'd63, 32'd0, 32'd1);
        push_cmd(CMD_UNKNOWN, 6'd1, 6'd1, 32'hffffffff, 32'hffffffff);
        for (int k = 0; k < 3; k++) push_cmd(CMD_READ, 6'd0, 6'(k), 32'd0, 32'd1);
        push_cmd(CMD_RUN, 6'd0, 6'd0, 32'd0, 32'd1);
        for (int r = 0; r < 2; r++)
            for (int k = 0; k < 3; k++) push_cmd(CMD_READ, 6'(r), 6'(k), 32'd0, 32'd1);
        wait_idle();

        // zero time step: each run makes one step and changes nothing
        apply_setting(32'd0, 32'h30000, 32'hffffffff, 32'd1, 32'd1, 7'd3, 7'd3);
        random_items(95);
        wait_idle();

        // no conduction, largest divisors
        apply_setting(32'd1, 32'd0, 32'd0, 32'hffffffff, 32'hffffffff, 7'd1, 7'd4);
        random_items(90);
        wait_idle();

        // four steps; receiver holds off while items keep coming
        apply_setting(32'h40000000, 32'hffffffff, 32'h10000, 32'h10000, 32'd1, 7'd2, 7'd2);
        @(negedge i_clk);
        stall_req = 1'b1;
        for (int n = 0; n < 30; n++) push_cmd(CMD_READ, 6'd1, 6'd1, 32'd0, 32'd1);
        random_items(65);
        wait_idle();

        // rows beyond the limit clamp to a full column
        apply_setting(32'hffffffff, 32'hffffffff, 32'h8000, 32'h1000, 32'd3, 7'd127, 7'd1);
        random_items(95);
        wait_idle();

        // zero size counts as one cell
        apply_setting(32'h10000, 32'h20000, 32'h20000, 32'h10000, 32'd1000, 7'd0, 7'd0);
        random_items(60);
        wait_idle();

        // one row, full width
        apply_setting(32'h10000, 32'd0, 32'h10000, 32'h10000, 32'd1, 7'd1, 7'd64);
        random_items(95);
        wait_idle();

        // sender pauses until everything is back, then random settings
        for (int s = 0; s < 2; s++) begin
            dt = $urandom_range(1, 32'h7fffffff);
            if (s == 1) quiet = 1'b1;
            apply_setting(dt, dt * $urandom_range(0, 2), $urandom(),
                          $urandom_range(1, 32'h20000), $urandom_range(1, 64),
                          7'($urandom_range(1, 3)), 7'($urandom_range(1, 3)));
            random_items(45);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
